// File: rtl/latd_pkg.sv
// Shared types and constants for the locality-aware task dispatcher.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package latd_pkg;

  // Fixed field widths of the item and result beats
  localparam int NODE_W   = 16;
  localparam int CHUNK_W  = 16;
  localparam int WID_W    = 4;
  localparam int HOME_OUT_W = 4;
  localparam int WC_W     = 5;
  // Home worker width: node mod worker_count, worker_count up to 31
  localparam int HOME_W   = 5;

  // Remainder unit: bits of the node number retired per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = NODE_W / DIV_BITS;
  localparam int DIV_CW    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_WORKER_COUNT = 1'b0;
  localparam logic [WC_W-1:0] WC_RESET = 5'd1;

  // Parameter defaults
  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_MAX_WORKERS = 16;
  localparam int DEF_CHUNK_BITS  = 16;

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    ST_DISPATCHED = 2'd0,
    ST_NO_TASK    = 2'd1,
    ST_ADDED      = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    logic    div_step;
    logic    add_write;
    logic    retire;
    logic    fin_capture;
    logic    scan_init;
    logic    scan;
    logic    shift;
    logic    commit;
    logic    load_out;
    status_t code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic div_last;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/locality_aware_task_dispatcher_unit.sv
// Top level of the locality-aware task dispatcher: worker_count register,
// APB-style configuration port, controller and datapath.
// Depends on latd_pkg, latd_ctrl, latd_dpath (and latd_ram through it).
`timescale 1ns / 1ps

// The block keeps an ordered queue of up to QUEUE_DEPTH tasks in one RAM and
// answers every item with one result beat. An add (operation 0) reduces the
// node number modulo worker_count in a serial remainder unit, four node bits
// per cycle, and appends the task unless the queue is full. A worker request
// (operation 1) retires the task the worker holds, then scans the queue RAM
// one entry per cycle for the oldest task homed at that worker and closes
// the gap by moving each younger entry down one slot per cycle, falling back
// to the oldest task when no home match exists; on an empty queue it
// answers with no task. One item is in work at a time; the next one is taken
// once the current result sits in the output register, and a result waiting
// on out_stall blocks only the hand-off of the following result.
module locality_aware_task_dispatcher_unit #(
  parameter int QUEUE_DEPTH = latd_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_WORKERS = latd_pkg::DEF_MAX_WORKERS,
  parameter int CHUNK_BITS  = latd_pkg::DEF_CHUNK_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [latd_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [latd_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [latd_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready,
  // item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [latd_pkg::CHUNK_W-1:0]    in_chunk_id,
  input  logic [latd_pkg::NODE_W-1:0]     in_node_id,
  input  logic [latd_pkg::WID_W-1:0]      in_worker_id,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [latd_pkg::CHUNK_W-1:0]    out_task_chunk,
  output logic [latd_pkg::HOME_OUT_W-1:0] out_task_home,
  output logic                            out_finished_valid,
  output logic [latd_pkg::CHUNK_W-1:0]    out_finished_chunk
);
  import latd_pkg::*;

  logic [WC_W-1:0]   wc_r;
  logic [HOME_W-1:0] eff_workers;
  logic              cfg_wr;
  logic              reg_sel;
  cmd_t              cmd;
  sts_t              sts;

  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= WC_RESET;
    end else if (cfg_wr && (reg_sel == REG_WORKER_COUNT)) begin
      wc_r <= cfg_pwdata[WC_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_sel)
      REG_WORKER_COUNT: cfg_prdata = CFG_DW'(wc_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // zero counts as one worker, clamp at MAX_WORKERS
  always_comb begin
    if (wc_r == '0) begin
      eff_workers = HOME_W'(1);
    end else if (32'(wc_r) > 32'(MAX_WORKERS)) begin
      eff_workers = HOME_W'(MAX_WORKERS);
    end else begin
      eff_workers = HOME_W'(wc_r);
    end
  end

  latd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_operation(in_operation),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  latd_dpath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_WORKERS(MAX_WORKERS),
    .CHUNK_BITS (CHUNK_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .eff_workers       (eff_workers),
    .in_chunk_id       (in_chunk_id),
    .in_node_id        (in_node_id),
    .in_worker_id      (in_worker_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_task_chunk    (out_task_chunk),
    .out_task_home     (out_task_home),
    .out_finished_valid(out_finished_valid),
    .out_finished_chunk(out_finished_chunk)
  );

endmodule

// File: rtl/latd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module latd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/latd_ctrl.sv
// Sequencing state machine of the task dispatcher.
// Depends on latd_pkg for the command/status structs and result codes.
`timescale 1ns / 1ps

module latd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_operation,
  output logic           in_stall,
  input  latd_pkg::sts_t sts,
  output latd_pkg::cmd_t cmd
);
  import latd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_ADD   = 8'b0000_0100,
    S_RET   = 8'b0000_1000,
    S_RWAIT = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_SHIFT = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.code  = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_operation == OP_REQUEST) begin
            state_nxt = S_RET;
          end else if (sts.full) begin
            code_nxt  = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_write = 1'b1;
        code_nxt      = ST_ADDED;
        state_nxt     = S_DONE;
      end
      S_RET: begin
        cmd.retire = 1'b1;
        state_nxt  = S_RWAIT;
      end
      S_RWAIT: begin
        cmd.fin_capture = 1'b1;
        cmd.scan_init   = 1'b1;
        if (sts.empty) begin
          code_nxt  = ST_NO_TASK;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          cmd.commit = 1'b1;
          code_nxt   = ST_DISPATCHED;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_NO_TASK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// File: rtl/latd_dpath.sv
// Datapath of the task dispatcher: queue RAM, held-chunk RAM, busy bits,
// serial remainder unit, scan and compaction pointers, output register.
// Depends on latd_pkg and latd_ram.
`timescale 1ns / 1ps

module latd_dpath #(
  parameter int QUEUE_DEPTH = latd_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_WORKERS = latd_pkg::DEF_MAX_WORKERS,
  parameter int CHUNK_BITS  = latd_pkg::DEF_CHUNK_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  latd_pkg::cmd_t                    cmd,
  output latd_pkg::sts_t                    sts,
  input  logic [latd_pkg::HOME_W-1:0]       eff_workers,
  input  logic [latd_pkg::CHUNK_W-1:0]      in_chunk_id,
  input  logic [latd_pkg::NODE_W-1:0]       in_node_id,
  input  logic [latd_pkg::WID_W-1:0]        in_worker_id,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [latd_pkg::CHUNK_W-1:0]      out_task_chunk,
  output logic [latd_pkg::HOME_OUT_W-1:0]   out_task_home,
  output logic                              out_finished_valid,
  output logic [latd_pkg::CHUNK_W-1:0]      out_finished_chunk
);
  import latd_pkg::*;

  localparam int QA   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int WA   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int QW   = CHUNK_BITS + HOME_W;

  // latched item
  logic [CHUNK_BITS-1:0] chunk_r;
  logic [WID_W-1:0]      wid_r;
  logic [31:0]           chunk_in_ext;
  logic [31:0]           wid_ext;
  logic [WA-1:0]         wid_idx;
  logic                  tracked;

  // queue and worker state
  logic [CNTW-1:0]        count_r;
  logic [MAX_WORKERS-1:0] busy_r;

  // remainder unit
  logic [NODE_W-1:0] div_node_r;
  logic [HOME_W-1:0] div_rem_r, div_rem_nxt;
  logic [DIV_CW-1:0] div_cnt_r;

  // retire
  logic                  fin_valid_r;
  logic [CHUNK_BITS-1:0] fin_chunk_r;

  // scan and compaction
  logic [CNTW-1:0] scan_addr_r;
  logic            chk_v_r;
  logic [CNTW-1:0] chk_addr_r;
  logic [QW-1:0]   first_r;
  logic [CNTW-1:0] pick_nxt;
  logic [QW-1:0]   pdata_r, pdata_nxt;
  logic [CNTW-1:0] sh_rd_r;
  logic            sh_v_r;
  logic [CNTW-1:0] sh_wr_r;
  logic            hit;
  logic            scan_end;
  logic            scan_rd_ok;
  logic            sh_rd_ok;

  // RAM ports
  logic            q_we, q_re;
  logic [QA-1:0]   q_waddr, q_raddr;
  logic [QW-1:0]   q_wdata, q_rdata;
  logic            w_we, w_re;
  logic [CHUNK_BITS-1:0] w_rdata;

  // output register
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [CHUNK_W-1:0]    out_chunk_r;
  logic [HOME_OUT_W-1:0] out_home_r;
  logic                  out_fin_v_r;
  logic [CHUNK_W-1:0]    out_fin_chunk_r;
  logic [31:0]           pchunk_ext;
  logic [31:0]           fchunk_ext;

  assign chunk_in_ext = 32'(in_chunk_id);
  assign wid_ext      = 32'(wid_r);
  assign wid_idx      = wid_ext[WA-1:0];
  assign tracked      = (wid_ext < 32'(MAX_WORKERS));

  // ---------------- remainder unit: DIV_BITS restoring steps per cycle
  always_comb begin
    logic [HOME_W:0] t;
    div_rem_nxt = div_rem_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {div_rem_nxt, div_node_r[NODE_W-1-k]};
      if (t >= {1'b0, eff_workers}) begin
        t = t - {1'b0, eff_workers};
      end
      div_rem_nxt = t[HOME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      div_node_r <= in_node_id;
      div_rem_r  <= '0;
      div_cnt_r  <= '0;
    end else if (cmd.div_step) begin
      div_node_r <= div_node_r << DIV_BITS;
      div_rem_r  <= div_rem_nxt;
      div_cnt_r  <= div_cnt_r + 1'b1;
    end
  end

  // ---------------- scan and compaction control
  assign scan_rd_ok = (scan_addr_r < count_r);
  assign sh_rd_ok   = (sh_rd_r < count_r);
  assign hit        = chk_v_r && (q_rdata[QW-1:CHUNK_BITS] == HOME_W'(wid_r));
  assign scan_end   = !chk_v_r && !scan_rd_ok;

  always_comb begin
    if (hit) begin
      pick_nxt  = chk_addr_r;
      pdata_nxt = q_rdata;
    end else begin
      // no home match: take the oldest task
      pick_nxt  = '0;
      pdata_nxt = first_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_v_r <= 1'b0;
      sh_v_r  <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        scan_addr_r <= '0;
        chk_v_r     <= 1'b0;
      end else if (cmd.scan) begin
        chk_v_r     <= scan_rd_ok;
        chk_addr_r  <= scan_addr_r;
        scan_addr_r <= scan_addr_r + 1'b1;
        if (chk_v_r && (chk_addr_r == '0)) begin
          first_r <= q_rdata;
        end
        if (hit || scan_end) begin
          pdata_r <= pdata_nxt;
          sh_rd_r <= pick_nxt + 1'b1;
          sh_v_r  <= 1'b0;
        end
      end else if (cmd.shift) begin
        sh_v_r  <= sh_rd_ok;
        sh_wr_r <= sh_rd_r - 1'b1;
        sh_rd_r <= sh_rd_r + 1'b1;
      end
    end
  end

  // ---------------- queue RAM
  always_comb begin
    q_we    = 1'b0;
    q_waddr = count_r[QA-1:0];
    q_wdata = {div_rem_r, chunk_r};
    if (cmd.add_write) begin
      q_we = 1'b1;
    end else if (cmd.shift && sh_v_r) begin
      // pull the next entry down one slot
      q_we    = 1'b1;
      q_waddr = sh_wr_r[QA-1:0];
      q_wdata = q_rdata;
    end
    q_re    = 1'b0;
    q_raddr = scan_addr_r[QA-1:0];
    if (cmd.scan) begin
      q_re = scan_rd_ok;
    end else if (cmd.shift) begin
      q_re    = sh_rd_ok;
      q_raddr = sh_rd_r[QA-1:0];
    end
  end

  latd_ram #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_qram (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .re   (q_re),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

  // ---------------- held-chunk RAM, one entry per worker
  assign w_we = cmd.commit && tracked;
  assign w_re = cmd.retire;

  latd_ram #(
    .WIDTH(CHUNK_BITS),
    .DEPTH(MAX_WORKERS)
  ) u_wram (
    .clk  (clk),
    .we   (w_we),
    .waddr(wid_idx),
    .wdata(pdata_r[CHUNK_BITS-1:0]),
    .re   (w_re),
    .raddr(wid_idx),
    .rdata(w_rdata)
  );

  // ---------------- item latch, count, busy bits, retire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= '0;
    end else begin
      if (cmd.add_write) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.commit) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.retire && tracked) begin
        busy_r[wid_idx] <= 1'b0;
      end else if (cmd.commit && tracked) begin
        busy_r[wid_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      chunk_r     <= chunk_in_ext[CHUNK_BITS-1:0];
      wid_r       <= in_worker_id;
      fin_valid_r <= 1'b0;
      fin_chunk_r <= '0;
    end else begin
      if (cmd.retire) begin
        fin_valid_r <= tracked && busy_r[wid_idx];
      end
      if (cmd.fin_capture) begin
        fin_chunk_r <= fin_valid_r ? w_rdata : '0;
      end
    end
  end

  // ---------------- output register
  assign pchunk_ext = 32'(pdata_r[CHUNK_BITS-1:0]);
  assign fchunk_ext = 32'(fin_chunk_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r    <= cmd.code;
      out_fin_v_r     <= fin_valid_r;
      out_fin_chunk_r <= fchunk_ext[CHUNK_W-1:0];
      if (cmd.code == ST_DISPATCHED) begin
        out_chunk_r <= pchunk_ext[CHUNK_W-1:0];
        out_home_r  <= pdata_r[CHUNK_BITS +: HOME_OUT_W];
      end else begin
        out_chunk_r <= '0;
        out_home_r  <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_task_chunk     = out_chunk_r;
  assign out_task_home      = out_home_r;
  assign out_finished_valid = out_fin_v_r;
  assign out_finished_chunk = out_fin_chunk_r;

  // ---------------- status back to the controller
  assign sts.full       = (count_r == CNTW'(QUEUE_DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.div_last   = (div_cnt_r == DIV_CW'(DIV_STEPS - 1));
  assign sts.scan_done  = hit || scan_end;
  assign sts.shift_done = !sh_v_r && !sh_rd_ok;
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule
